@@ rtl/bsd_pkg.sv @@
package bsd_pkg;

	// Saturation limits; the run and indent registers are 8 bits wide.
	localparam int MAX_NEWLINE_RUN = 255;
	localparam int MAX_INDENT = 255;
	localparam logic [7:0] RUN_CAP = 8'((MAX_NEWLINE_RUN < 255) ? MAX_NEWLINE_RUN : 255);
	localparam logic [7:0] IND_CAP = 8'((MAX_INDENT < 255) ? MAX_INDENT : 255);

	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_ZERO = 8'h30;

	typedef enum logic [2:0] {
		PH_IND,
		PH_MOD,
		PH_WS,
		PH_COMMENT,
		PH_CR,
		PH_LINE,
		PH_CONTENT,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		TAIL_CLIP,
		TAIL_STRIP,
		TAIL_KEEP
	} chomp_t;

	typedef enum logic [1:0] {
		END_EOI,
		END_DEDENT,
		END_TAB
	} end_reason_t;

	typedef struct packed {
		logic [7:0] newline_run;
		logic       char_valid;
		logic [7:0] out_char;
		logic       done_res;
		logic [1:0] end_reason;
		logic       handed_back;
		logic       overflow;
		logic       last;
	} res_t;

endpackage

@@ rtl/block_scalar_decoder_unit.sv @@
// Block scalar decoder: one document byte in per transfer, up to two results out.
// Results pass through the input register and then the result queue.
// Throughput: one byte per cycle while the result queue has room; a folding space yields
// a second result, and the input stage waits while the two-entry queue cannot take them.
// Reset (arst_n low, asynchronous): decoder back to expecting the indicator,
// input stage and result queue emptied.
module block_scalar_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] newline_run,
	output logic       char_valid,
	output logic [7:0] out_char,
	output logic       done_res,
	output logic [1:0] end_reason,
	output logic       handed_back,
	output logic       overflow,
	output logic       last
);
	import bsd_pkg::*;

	// Input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// Decoder state
	phase_t     phase_q;
	logic       folded_q;
	chomp_t     chomp_q;
	logic       indent_known_q;
	logic [7:0] block_indent_q;
	logic [7:0] line_indent_q;
	logic [7:0] pending_q;
	logic       has_content_q;
	logic       any_output_q;
	logic       lost_q;

	// Next-state values
	phase_t     phase_d;
	logic       folded_d;
	chomp_t     chomp_d;
	logic       indent_known_d;
	logic [7:0] block_indent_d;
	logic [7:0] line_indent_d;
	logic [7:0] pending_d;
	logic       has_content_d;
	logic       any_output_d;
	logic       lost_d;

	// Results for the byte in stage 1
	res_t       res0;
	res_t       res1;
	logic [1:0] nres;
	logic       do_line;

	// Two-entry result queue
	res_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] free_slots;
	logic       fire;

	// Run released at the end of the block, after chomping.
	function automatic logic [7:0] chomp_run(chomp_t mode, logic anyout, logic [7:0] pend);
		logic [7:0] run;
		case (mode)
			TAIL_STRIP: run = 8'd0;
			TAIL_KEEP:  run = pend;
			default:    run = (anyout && pend != 8'd0) ? 8'd1 : 8'd0;
		endcase
		return run;
	endfunction

	// Decode step: everything one byte does to the state, in one pass.
	always_comb begin
		phase_d        = phase_q;
		folded_d       = folded_q;
		chomp_d        = chomp_q;
		indent_known_d = indent_known_q;
		block_indent_d = block_indent_q;
		line_indent_d  = line_indent_q;
		pending_d      = pending_q;
		has_content_d  = has_content_q;
		any_output_d   = any_output_q;
		lost_d         = lost_q;
		res0           = '0;
		res1           = '0;
		nres           = 2'd0;
		do_line        = 1'b0;

		if (phase_q == PH_DONE) begin
			// Block already ended: swallow everything until reset.
		end else if (eoi_s1) begin
			res0.newline_run = chomp_run(chomp_q, any_output_q, pending_q);
			res0.done_res    = 1'b1;
			res0.end_reason  = END_EOI;
			res0.overflow    = lost_q;
			nres             = 2'd1;
			pending_d        = 8'd0;
			lost_d           = 1'b0;
			phase_d          = PH_DONE;
		end else begin
			case (phase_q)
				PH_IND: begin
					folded_d = (byte_s1 == CH_GT);
					phase_d  = PH_MOD;
				end
				PH_MOD, PH_WS: begin
					if (phase_q == PH_MOD && byte_s1 == CH_DASH) begin
						chomp_d = TAIL_STRIP;
					end else if (phase_q == PH_MOD && byte_s1 == CH_PLUS) begin
						chomp_d = TAIL_KEEP;
					end else if (phase_q == PH_MOD && byte_s1 >= CH_ONE &&
							byte_s1 <= CH_NINE) begin
						block_indent_d = byte_s1 - CH_ZERO;
						indent_known_d = 1'b1;
					end else if (byte_s1 == CH_SPACE || byte_s1 == CH_TAB) begin
						phase_d = PH_WS;
					end else if (byte_s1 == CH_HASH) begin
						phase_d = PH_COMMENT;
					end else if (byte_s1 == CH_CR) begin
						phase_d = PH_CR;
					end else if (byte_s1 == CH_LF) begin
						phase_d       = PH_LINE;
						line_indent_d = 8'd0;
					end else begin
						// stray header byte opens the first line
						phase_d       = PH_LINE;
						line_indent_d = 8'd0;
						do_line       = 1'b1;
					end
				end
				PH_COMMENT: begin
					if (byte_s1 == CH_CR) begin
						phase_d = PH_CR;
					end else if (byte_s1 == CH_LF) begin
						phase_d       = PH_LINE;
						line_indent_d = 8'd0;
					end
				end
				PH_CR: begin
					phase_d       = PH_LINE;
					line_indent_d = 8'd0;
					do_line       = (byte_s1 != CH_LF);
				end
				PH_LINE: begin
					do_line = 1'b1;
				end
				default: begin
					// inside a content line
					if (byte_s1 == CH_CR || byte_s1 == CH_LF) begin
						if (pending_q < RUN_CAP) begin
							pending_d = pending_q + 8'd1;
						end else begin
							lost_d = 1'b1;
						end
						if (byte_s1 == CH_CR) begin
							phase_d = PH_CR;
						end else begin
							line_indent_d = 8'd0;
							phase_d       = PH_LINE;
						end
					end else begin
						res0.newline_run = pending_q;
						res0.char_valid  = 1'b1;
						res0.out_char    = byte_s1;
						res0.overflow    = lost_q;
						nres             = 2'd1;
						pending_d        = 8'd0;
						lost_d           = 1'b0;
						any_output_d     = 1'b1;
					end
				end
			endcase

			// Start-of-line handling: indentation, blank lines, first content byte.
			if (do_line) begin
				if (byte_s1 == CH_SPACE) begin
					if (line_indent_d < IND_CAP) begin
						line_indent_d = line_indent_d + 8'd1;
					end
				end else if (byte_s1 == CH_LF || byte_s1 == CH_CR) begin
					if (pending_q < RUN_CAP) begin
						pending_d = pending_q + 8'd1;
					end else begin
						lost_d = 1'b1;
					end
					if (byte_s1 == CH_LF) begin
						line_indent_d = 8'd0;
					end else begin
						phase_d = PH_CR;
					end
				end else if (byte_s1 == CH_TAB) begin
					res0.newline_run = chomp_run(chomp_q, any_output_q, pending_q);
					res0.done_res    = 1'b1;
					res0.end_reason  = END_TAB;
					res0.handed_back = 1'b1;
					res0.overflow    = lost_q;
					nres             = 2'd1;
					pending_d        = 8'd0;
					lost_d           = 1'b0;
					phase_d          = PH_DONE;
				end else begin
					// first content line fixes the indent
					if (!indent_known_d) begin
						block_indent_d = line_indent_d;
						indent_known_d = 1'b1;
					end
					if (line_indent_d < block_indent_d) begin
						// dedent: hand the byte back and close
						res0.newline_run = chomp_run(chomp_q, any_output_q, pending_q);
						res0.done_res    = 1'b1;
						res0.end_reason  = END_DEDENT;
						res0.handed_back = 1'b1;
						res0.overflow    = lost_q;
						nres             = 2'd1;
						pending_d        = 8'd0;
						lost_d           = 1'b0;
						phase_d          = PH_DONE;
					end else if (folded_q && has_content_q && pending_q <= 8'd1) begin
						// single break folds into a space ahead of the char
						res0.char_valid  = 1'b1;
						res0.out_char    = CH_SPACE;
						res1.char_valid  = 1'b1;
						res1.out_char    = byte_s1;
						res1.overflow    = lost_q;
						nres             = 2'd2;
						pending_d        = 8'd0;
						lost_d           = 1'b0;
						any_output_d     = 1'b1;
						has_content_d    = 1'b1;
						phase_d          = PH_CONTENT;
					end else begin
						// folded mode drops the first of several breaks
						res0.newline_run = (folded_q && has_content_q) ?
							pending_q - 8'd1 : pending_q;
						res0.char_valid  = 1'b1;
						res0.out_char    = byte_s1;
						res0.overflow    = lost_q;
						nres             = 2'd1;
						pending_d        = 8'd0;
						lost_d           = 1'b0;
						any_output_d     = 1'b1;
						has_content_d    = 1'b1;
						phase_d          = PH_CONTENT;
					end
				end
			end
		end

		// Tag the final result of this byte.
		if (nres == 2'd2) begin
			res1.last = 1'b1;
		end else if (nres == 2'd1) begin
			res0.last = 1'b1;
		end
	end

	// Queue bookkeeping: the byte in stage 1 advances only when its results fit.
	assign pop        = (cnt_q != 2'd0) && !out_stall;
	assign free_slots = 2'd2 - cnt_q + {1'b0, pop};
	assign fire       = valid_s1 && (nres <= free_slots);
	assign in_stall   = valid_s1 && !fire;

	// Input register: load whenever the stage is empty or moving on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= in_byte;
			eoi_s1  <= end_of_input;
		end
	end

	// Decoder state advances once per byte that leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IND;
			folded_q       <= 1'b0;
			chomp_q        <= TAIL_CLIP;
			indent_known_q <= 1'b0;
			block_indent_q <= 8'd0;
			line_indent_q  <= 8'd0;
			pending_q      <= 8'd0;
			has_content_q  <= 1'b0;
			any_output_q   <= 1'b0;
			lost_q         <= 1'b0;
		end else if (fire) begin
			phase_q        <= phase_d;
			folded_q       <= folded_d;
			chomp_q        <= chomp_d;
			indent_known_q <= indent_known_d;
			block_indent_q <= block_indent_d;
			line_indent_q  <= line_indent_d;
			pending_q      <= pending_d;
			has_content_q  <= has_content_d;
			any_output_q   <= any_output_d;
			lost_q         <= lost_d;
		end
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (fire) begin
				wr_ptr_q <= wr_ptr_q ^ nres[0];
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q - {1'b0, pop} + (fire ? nres : 2'd0);
		end
	end

	// Result slots: hold payload, written in order from the write pointer.
	always_ff @(posedge clk) begin
		if (fire && nres != 2'd0) begin
			ent_q[wr_ptr_q] <= res0;
		end
		if (fire && nres == 2'd2) begin
			ent_q[~wr_ptr_q] <= res1;
		end
	end

	assign out_valid   = (cnt_q != 2'd0);
	assign newline_run = ent_q[rd_ptr_q].newline_run;
	assign char_valid  = ent_q[rd_ptr_q].char_valid;
	assign out_char    = ent_q[rd_ptr_q].out_char;
	assign done_res    = ent_q[rd_ptr_q].done_res;
	assign end_reason  = ent_q[rd_ptr_q].end_reason;
	assign handed_back = ent_q[rd_ptr_q].handed_back;
	assign overflow    = ent_q[rd_ptr_q].overflow;
	assign last        = ent_q[rd_ptr_q].last;

endmodule
